>>> hdl/cdu_pkg.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// cdu_pkg: shared types, constants and functions of the calendar date unit
// Field widths, calendar limits, the month length lookup and the structs that
// carry a date and its year terms between the date check and the top level.
//------------------------------------------------------------------------------
package cdu_pkg;

   localparam int unsigned DAY_W   = 5;
   localparam int unsigned MONTH_W = 4;
   localparam int unsigned YEAR_W  = 14;
   localparam int unsigned NUM_W   = 22;
   localparam int unsigned ACC_W   = 24;

   localparam int unsigned EPOCH_YEAR = 1950;
   localparam int unsigned YEAR_LIMIT = 10000;

   localparam int unsigned MONTH_JAN = 1;
   localparam int unsigned MONTH_FEB = 2;
   localparam int unsigned MONTH_DEC = 12;

   // floor(y / 100) == (y * RECIP_100) >> RECIP_SHIFT for every 14-bit y
   localparam int unsigned RECIP_100   = 5243;
   localparam int unsigned RECIP_W     = 13;
   localparam int unsigned RECIP_SHIFT = 19;
   localparam int unsigned PROD_W      = YEAR_W + RECIP_W;

   localparam int unsigned Q4_W   = YEAR_W - 2;
   localparam int unsigned Q100_W = PROD_W - RECIP_SHIFT;
   localparam int unsigned Q400_W = Q100_W - 2;

   // Days in years 1 .. EPOCH_YEAR-1
   localparam int unsigned EPOCH_BASE = 365 * (EPOCH_YEAR - 1) + (EPOCH_YEAR - 1) / 4
                                      - (EPOCH_YEAR - 1) / 100 + (EPOCH_YEAR - 1) / 400;

   typedef struct packed {
      logic [DAY_W-1:0]   day;
      logic [MONTH_W-1:0] month;
      logic [YEAR_W-1:0]  year;
   } date_type;

   // A date with its validity, leap flag and the quotients of year-1
   typedef struct packed {
      date_type            date;
      logic                valid;
      logic                leap;
      logic [Q4_W-1:0]     n4;
      logic [Q100_W-1:0]   n100;
      logic [Q400_W-1:0]   n400;
   } date_info_type;

   function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] month,
                                                   input logic leap);
      logic [DAY_W-1:0] len;
      case (month) inside
         4'd4, 4'd6, 4'd9, 4'd11: len = DAY_W'(30);
         MONTH_W'(MONTH_FEB):     len = leap ? DAY_W'(29) : DAY_W'(28);
         default:                 len = DAY_W'(31);
      endcase
      return len;
   endfunction

endpackage

>>> hdl/cdu_date_check.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// cdu_date_check: validity, leap year and year quotients of one date
// Divides the year by 100 through a reciprocal multiply, derives the leap flag
// and the /4, /100 and /400 quotients of year-1 for the day count.
//------------------------------------------------------------------------------
module cdu_date_check
   import cdu_pkg::*;
(
   input  date_type      date,
   output date_info_type info
);

   logic [PROD_W-1:0] prod;
   logic [Q100_W-1:0] q100;
   logic [YEAR_W-1:0] hund;
   logic [YEAR_W-1:0] r100;
   logic              div100;
   logic              div4;
   logic              div400;
   logic              leap;
   logic              year_ok;
   logic              month_ok;
   logic              day_ok;

   assign prod   = PROD_W'(date.year) * PROD_W'(RECIP_100);
   assign q100   = prod[PROD_W-1:RECIP_SHIFT];
   assign hund   = YEAR_W'(q100) * YEAR_W'(100);
   assign r100   = date.year - hund;
   assign div100 = (r100 == '0);
   assign div4   = (date.year[1:0] == 2'b00);
   assign div400 = div100 && (q100[1:0] == 2'b00);
   assign leap   = div4 && (!div100 || div400);

   assign year_ok  = (date.year >= YEAR_W'(EPOCH_YEAR)) && (date.year < YEAR_W'(YEAR_LIMIT));
   assign month_ok = (date.month >= MONTH_W'(MONTH_JAN)) && (date.month <= MONTH_W'(MONTH_DEC));
   assign day_ok   = (date.day != '0) && (date.day <= month_days(date.month, leap));

   // quotients of year-1: step down where year itself is a multiple
   always_comb begin
      info.date  = date;
      info.valid = year_ok && month_ok && day_ok;
      info.leap  = leap;
      info.n4    = date.year[YEAR_W-1:2] - Q4_W'(div4);
      info.n100  = q100 - Q100_W'(div100);
      info.n400  = q100[Q100_W-1:2] - Q400_W'(div400);
   end

endmodule

>>> hdl/calendar_date_unit.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// calendar_date_unit: Gregorian date checker, day counter and next-day logic
// Takes two dates per transaction and returns validity, A's day number from
// 1 January 1950, the order of A and B, their inclusive distance when A is
// not before B, and A's next day with overflow past year 9999.
//
// Usage:
//  - Request channel req_*: a transaction moves at a clock edge with req_valid
//    high and req_stall low. Response channel rsp_*: same rule on rsp_valid
//    and rsp_stall.
//  - Four register stages: input, year terms, day numbers, result. A taken
//    request moves through them in that order to become its response.
//  - One transaction per cycle sustained while rsp_stall is low; no dependence between transactions.
//  - When rsp_stall holds the result register, the stages behind it fill;
//    req_stall rises only once all four hold a transaction.
//  - Synchronous reset empties every stage by clearing its valid flag; the data registers are not reset.
//  - Results that need an invalid date are zero.
//------------------------------------------------------------------------------
module calendar_date_unit
   import cdu_pkg::*;
(
   input  logic               clock,
   input  logic               reset,

   input  logic               req_valid,
   output logic               req_stall,
   input  logic [DAY_W-1:0]   req_day_a,
   input  logic [MONTH_W-1:0] req_month_a,
   input  logic [YEAR_W-1:0]  req_year_a,
   input  logic [DAY_W-1:0]   req_day_b,
   input  logic [MONTH_W-1:0] req_month_b,
   input  logic [YEAR_W-1:0]  req_year_b,

   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_a_valid,
   output logic               rsp_b_valid,
   output logic [NUM_W-1:0]   rsp_a_day_number,
   output logic               rsp_a_before_b,
   output logic               rsp_dates_equal,
   output logic [NUM_W-1:0]   rsp_days_between,
   output logic [DAY_W-1:0]   rsp_next_day_of_month,
   output logic [MONTH_W-1:0] rsp_next_month,
   output logic [YEAR_W-1:0]  rsp_next_year,
   output logic               rsp_next_overflow
);

   typedef struct packed {
      logic               va;
      logic               vb;
      logic               eq;
      logic [NUM_W-1:0]   na;
      logic [NUM_W-1:0]   nb;
      logic [DAY_W-1:0]   nd;
      logic [MONTH_W-1:0] nm;
      logic [YEAR_W-1:0]  ny;
      logic               ovf;
   } calc_type;

   typedef struct packed {
      logic               a_valid;
      logic               b_valid;
      logic [NUM_W-1:0]   a_day_number;
      logic               a_before_b;
      logic               dates_equal;
      logic [NUM_W-1:0]   days_between;
      logic [DAY_W-1:0]   next_dom;
      logic [MONTH_W-1:0] next_month;
      logic [YEAR_W-1:0]  next_year;
      logic               next_overflow;
   } rsp_type;

   // Days before a month in a common year
   function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] month);
      logic [8:0] d;
      case (month)
         4'd2:    d = 9'd31;
         4'd3:    d = 9'd59;
         4'd4:    d = 9'd90;
         4'd5:    d = 9'd120;
         4'd6:    d = 9'd151;
         4'd7:    d = 9'd181;
         4'd8:    d = 9'd212;
         4'd9:    d = 9'd243;
         4'd10:   d = 9'd273;
         4'd11:   d = 9'd304;
         4'd12:   d = 9'd334;
         default: d = 9'd0;
      endcase
      return d;
   endfunction

   // Day number of a valid date, 1 January of the epoch year is day 1
   function automatic logic [NUM_W-1:0] day_number(input date_info_type info);
      logic [ACC_W-1:0] n;
      logic [ACC_W-1:0] sum;
      logic             leap_add;
      n        = ACC_W'(info.date.year) - ACC_W'(1);
      leap_add = info.leap && (info.date.month > MONTH_W'(MONTH_FEB));
      sum      = n * ACC_W'(365) + ACC_W'(info.n4) - ACC_W'(info.n100) + ACC_W'(info.n400)
               - ACC_W'(EPOCH_BASE) + ACC_W'(days_before(info.date.month))
               + ACC_W'(leap_add) + ACC_W'(info.date.day);
      return sum[NUM_W-1:0];
   endfunction

   //---------------------------------------------------------------------------
   // Stage control: each stage loads when empty or when the next one moves
   //---------------------------------------------------------------------------
   logic in_vld_ff,   in_vld_in,   in_rdy;
   logic mid_vld_ff,  mid_vld_in,  mid_rdy;
   logic calc_vld_ff, calc_vld_in, calc_rdy;
   logic out_vld_ff,  out_vld_in,  out_rdy;

   assign out_rdy  = !out_vld_ff  || !rsp_stall;
   assign calc_rdy = !calc_vld_ff || out_rdy;
   assign mid_rdy  = !mid_vld_ff  || calc_rdy;
   assign in_rdy   = !in_vld_ff   || mid_rdy;

   assign in_vld_in   = in_rdy   ? req_valid   : in_vld_ff;
   assign mid_vld_in  = mid_rdy  ? in_vld_ff   : mid_vld_ff;
   assign calc_vld_in = calc_rdy ? mid_vld_ff  : calc_vld_ff;
   assign out_vld_in  = out_rdy  ? calc_vld_ff : out_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff   <= 1'b0;
         mid_vld_ff  <= 1'b0;
         calc_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         in_vld_ff   <= in_vld_in;
         mid_vld_ff  <= mid_vld_in;
         calc_vld_ff <= calc_vld_in;
         out_vld_ff  <= out_vld_in;
      end
   end

   assign req_stall = !in_rdy;
   assign rsp_valid = out_vld_ff;

   //---------------------------------------------------------------------------
   // Input register: capture both dates of the transaction
   //---------------------------------------------------------------------------
   date_type in_a_ff, in_a_in;
   date_type in_b_ff, in_b_in;

   always_comb begin
      in_a_in = in_a_ff;
      in_b_in = in_b_ff;
      if (in_rdy) begin
         in_a_in = '{day: req_day_a, month: req_month_a, year: req_year_a};
         in_b_in = '{day: req_day_b, month: req_month_b, year: req_year_b};
      end
   end

   //---------------------------------------------------------------------------
   // Year terms: validity, leap flag and quotients for each date
   //---------------------------------------------------------------------------
   date_info_type info_a, info_b;
   date_info_type mid_a_ff, mid_a_in;
   date_info_type mid_b_ff, mid_b_in;

   cdu_date_check u_check_a (
      .date (in_a_ff),
      .info (info_a)
   );

   cdu_date_check u_check_b (
      .date (in_b_ff),
      .info (info_b)
   );

   assign mid_a_in = mid_rdy ? info_a : mid_a_ff;
   assign mid_b_in = mid_rdy ? info_b : mid_b_ff;

   //---------------------------------------------------------------------------
   // Day numbers, equality and the date after A
   //---------------------------------------------------------------------------
   calc_type           calc;
   calc_type           calc_ff, calc_in;
   logic [DAY_W-1:0]   len_a;
   logic [DAY_W-1:0]   nd;
   logic [MONTH_W-1:0] nm;
   logic [YEAR_W-1:0]  ny;

   assign len_a = month_days(mid_a_ff.date.month, mid_a_ff.leap);

   always_comb begin
      // roll day into month, month into year
      nd = mid_a_ff.date.day + DAY_W'(1);
      nm = mid_a_ff.date.month;
      ny = mid_a_ff.date.year;
      if (mid_a_ff.date.day == len_a) begin
         nd = DAY_W'(1);
         nm = mid_a_ff.date.month + MONTH_W'(1);
      end
      if (mid_a_ff.date.month == MONTH_W'(MONTH_DEC) && mid_a_ff.date.day == len_a) begin
         nm = MONTH_W'(MONTH_JAN);
         ny = mid_a_ff.date.year + YEAR_W'(1);
      end

      calc = '0;
      calc.va = mid_a_ff.valid;
      calc.vb = mid_b_ff.valid;
      if (mid_a_ff.valid) begin
         calc.na = day_number(mid_a_ff);
         if (ny == YEAR_W'(YEAR_LIMIT)) begin
            calc.ovf = 1'b1;
         end else begin
            calc.nd = nd;
            calc.nm = nm;
            calc.ny = ny;
         end
      end
      if (mid_b_ff.valid) begin
         calc.nb = day_number(mid_b_ff);
      end
      calc.eq = mid_a_ff.valid && mid_b_ff.valid && (mid_a_ff.date == mid_b_ff.date);
   end

   assign calc_in = calc_rdy ? calc : calc_ff;

   //---------------------------------------------------------------------------
   // Result: order of A and B, and their inclusive distance when A is not before B
   //---------------------------------------------------------------------------
   rsp_type rsp;
   rsp_type out_ff, out_in;
   logic    both_ok;
   logic    a_first;

   assign both_ok = calc_ff.va && calc_ff.vb;
   assign a_first = both_ok && (calc_ff.na < calc_ff.nb);

   always_comb begin
      rsp.a_valid       = calc_ff.va;
      rsp.b_valid       = calc_ff.vb;
      rsp.a_day_number  = calc_ff.na;
      rsp.a_before_b    = a_first;
      rsp.dates_equal   = calc_ff.eq;
      rsp.days_between  = (both_ok && !a_first) ?
                          (calc_ff.na - calc_ff.nb + NUM_W'(1)) : '0;
      rsp.next_dom      = calc_ff.nd;
      rsp.next_month    = calc_ff.nm;
      rsp.next_year     = calc_ff.ny;
      rsp.next_overflow = calc_ff.ovf;
   end

   // hold the result while the receiver stalls
   assign out_in = out_rdy ? rsp : out_ff;

   always_ff @(posedge clock) begin
      in_a_ff  <= in_a_in;
      in_b_ff  <= in_b_in;
      mid_a_ff <= mid_a_in;
      mid_b_ff <= mid_b_in;
      calc_ff  <= calc_in;
      out_ff   <= out_in;
   end

   assign rsp_a_valid           = out_ff.a_valid;
   assign rsp_b_valid           = out_ff.b_valid;
   assign rsp_a_day_number      = out_ff.a_day_number;
   assign rsp_a_before_b        = out_ff.a_before_b;
   assign rsp_dates_equal       = out_ff.dates_equal;
   assign rsp_days_between      = out_ff.days_between;
   assign rsp_next_day_of_month = out_ff.next_dom;
   assign rsp_next_month        = out_ff.next_month;
   assign rsp_next_year         = out_ff.next_year;
   assign rsp_next_overflow     = out_ff.next_overflow;

endmodule

>>> tb/tb_calendar_date_unit.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// tb_calendar_date_unit: self-checking testbench of the calendar date unit
// Feeds pairs of dates through the request channel and checks every response
// against a behavioral Gregorian calendar model kept in this file. A short
// directed set covers leap rules, month ends, range limits and year 9999
// overflow, then random pairs follow: mostly valid dates with random content,
// plus equal pairs, nearby pairs and raw noise on every field. Both channels
// idle and stall at random, with calm stretches of back-to-back traffic.
//------------------------------------------------------------------------------
module tb_calendar_date_unit
   import cdu_pkg::*;
();

   localparam int unsigned RANDOM_PAIRS = 1450;
   localparam int unsigned CYCLE_LIMIT  = 200000;
   localparam int unsigned DRAIN_CYCLES = 12;
   localparam int unsigned MAX_REPORTS  = 10;

   // One request transaction: date A and date B
   typedef struct packed {
      date_type a;
      date_type b;
   } date_pair_type;

   // One response transaction, in port order
   typedef struct packed {
      logic               a_valid;
      logic               b_valid;
      logic [NUM_W-1:0]   a_day_number;
      logic               a_before_b;
      logic               dates_equal;
      logic [NUM_W-1:0]   days_between;
      logic [DAY_W-1:0]   next_dom;
      logic [MONTH_W-1:0] next_month;
      logic [YEAR_W-1:0]  next_year;
      logic               next_overflow;
   } date_report_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [DAY_W-1:0]   req_day_a;
   logic [MONTH_W-1:0] req_month_a;
   logic [YEAR_W-1:0]  req_year_a;
   logic [DAY_W-1:0]   req_day_b;
   logic [MONTH_W-1:0] req_month_b;
   logic [YEAR_W-1:0]  req_year_b;
   logic               rsp_valid;
   logic               rsp_stall;
   logic               rsp_a_valid;
   logic               rsp_b_valid;
   logic [NUM_W-1:0]   rsp_a_day_number;
   logic               rsp_a_before_b;
   logic               rsp_dates_equal;
   logic [NUM_W-1:0]   rsp_days_between;
   logic [DAY_W-1:0]   rsp_next_day_of_month;
   logic [MONTH_W-1:0] rsp_next_month;
   logic [YEAR_W-1:0]  rsp_next_year;
   logic               rsp_next_overflow;

   date_pair_type   pending_pairs[$];     // date pairs waiting to be driven
   date_report_type expected_reports[$];  // predicted responses, oldest first

   logic            req_taken;
   logic            rsp_taken;
   int unsigned     req_gap;
   int unsigned     req_calm;
   int unsigned     rsp_wait;
   int unsigned     rsp_calm;
   int unsigned     cycle_count;
   int unsigned     failures;
   date_pair_type   next_pair;
   date_report_type seen_report;
   date_report_type want_report;
   string           bad_fields;

   calendar_date_unit uut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_day_a             (req_day_a),
      .req_month_a           (req_month_a),
      .req_year_a            (req_year_a),
      .req_day_b             (req_day_b),
      .req_month_b           (req_month_b),
      .req_year_b            (req_year_b),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_a_valid           (rsp_a_valid),
      .rsp_b_valid           (rsp_b_valid),
      .rsp_a_day_number      (rsp_a_day_number),
      .rsp_a_before_b        (rsp_a_before_b),
      .rsp_dates_equal       (rsp_dates_equal),
      .rsp_days_between      (rsp_days_between),
      .rsp_next_day_of_month (rsp_next_day_of_month),
      .rsp_next_month        (rsp_next_month),
      .rsp_next_year         (rsp_next_year),
      .rsp_next_overflow     (rsp_next_overflow)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   //---------------------------------------------------------------------------
   // Calendar model
   //---------------------------------------------------------------------------

   function automatic bit is_leap(int unsigned y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
   endfunction

   function automatic int unsigned month_length(int unsigned m, int unsigned y);
      int unsigned len;
      case (m)
         4, 6, 9, 11: len = 30;
         MONTH_FEB:   len = is_leap(y) ? 29 : 28;
         default:     len = 31;
      endcase
      return len;
   endfunction

   // Days in years 1 .. n of the proleptic calendar
   function automatic int unsigned years_to_days(int unsigned n);
      return 365 * n + n / 4 - n / 100 + n / 400;
   endfunction

   function automatic bit date_ok(date_type d);
      if (d.year < EPOCH_YEAR || d.year >= YEAR_LIMIT) return 1'b0;
      if (d.month < MONTH_JAN || d.month > MONTH_DEC) return 1'b0;
      return (d.day >= 1) && (d.day <= month_length(d.month, d.year));
   endfunction

   // Day number with 1 January of the epoch year counted as day 1
   function automatic int unsigned ordinal_day(date_type d);
      int unsigned n;
      n = years_to_days(d.year - 1) - years_to_days(EPOCH_YEAR - 1);
      for (int unsigned k = MONTH_JAN; k < d.month; k++) n += month_length(k, d.year);
      return n + d.day;
   endfunction

   function automatic date_report_type predict_date_report(date_pair_type p);
      date_report_type r;
      int unsigned     na;
      int unsigned     nb;
      r = '0;
      r.a_valid = date_ok(p.a);
      r.b_valid = date_ok(p.b);
      if (r.a_valid) begin
         na = ordinal_day(p.a);
         r.a_day_number = NUM_W'(na);
         // Advance within the month, then roll month, then roll year
         if (p.a.day < month_length(p.a.month, p.a.year)) begin
            r.next_dom   = p.a.day + 1'b1;
            r.next_month = p.a.month;
            r.next_year  = p.a.year;
         end else if (p.a.month < MONTH_DEC) begin
            r.next_dom   = DAY_W'(1);
            r.next_month = p.a.month + 1'b1;
            r.next_year  = p.a.year;
         end else if (p.a.year + 1 < YEAR_LIMIT) begin
            r.next_dom   = DAY_W'(1);
            r.next_month = MONTH_W'(MONTH_JAN);
            r.next_year  = p.a.year + 1'b1;
         end else begin
            r.next_overflow = 1'b1;
         end
      end
      if (r.a_valid && r.b_valid) begin
         nb = ordinal_day(p.b);
         r.a_before_b   = (na < nb);
         r.dates_equal  = (p.a == p.b);
         r.days_between = r.a_before_b ? '0 : NUM_W'(na - nb + 1);
      end
      return r;
   endfunction

   //---------------------------------------------------------------------------
   // Stimulus helpers
   //---------------------------------------------------------------------------

   function automatic date_pair_type make_pair(int unsigned da, int unsigned ma,
                                               int unsigned ya, int unsigned db,
                                               int unsigned mb, int unsigned yb);
      date_pair_type p;
      p.a.day   = DAY_W'(da);
      p.a.month = MONTH_W'(ma);
      p.a.year  = YEAR_W'(ya);
      p.b.day   = DAY_W'(db);
      p.b.month = MONTH_W'(mb);
      p.b.year  = YEAR_W'(yb);
      return p;
   endfunction

   // Valid date, biased toward the range ends, century years and month ends
   function automatic date_type random_date();
      date_type    d;
      int unsigned y;
      int unsigned m;
      int unsigned len;
      case ($urandom_range(0, 9))
         0:       y = YEAR_LIMIT - 1;
         1:       y = EPOCH_YEAR;
         2:       y = $urandom_range(20, 99) * 100;
         3:       y = $urandom_range(1996, 2004);
         default: y = $urandom_range(EPOCH_YEAR, YEAR_LIMIT - 1);
      endcase
      m   = $urandom_range(MONTH_JAN, MONTH_DEC);
      len = month_length(m, y);
      d.year  = YEAR_W'(y);
      d.month = MONTH_W'(m);
      if ($urandom_range(0, 1)) d.day = DAY_W'(len - $urandom_range(0, 2));
      else d.day = DAY_W'($urandom_range(1, len));
      return d;
   endfunction

   // Any bit pattern on every field
   function automatic date_type noise_date();
      date_type d;
      d.day   = DAY_W'($urandom_range(0, (1 << DAY_W) - 1));
      d.month = MONTH_W'($urandom_range(0, (1 << MONTH_W) - 1));
      d.year  = YEAR_W'($urandom_range(0, (1 << YEAR_W) - 1));
      return d;
   endfunction

   // Idle length for one transaction, with occasional calm stretches of zero
   function automatic int unsigned draw_wait(inout int unsigned calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 31) == 0) begin
         calm = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, 4);
   endfunction

   //---------------------------------------------------------------------------
   // Request driver: change inputs at the falling edge only
   //---------------------------------------------------------------------------
   always @(negedge clock) begin
      if (!reset) begin
         if (req_valid && !req_taken) begin
            // hold the stalled transaction as it is
         end else if (req_gap > 0) begin
            req_valid <= 1'b0;
            req_gap--;
         end else if (pending_pairs.size() > 0) begin
            next_pair   = pending_pairs.pop_front();
            req_day_a   <= next_pair.a.day;
            req_month_a <= next_pair.a.month;
            req_year_a  <= next_pair.a.year;
            req_day_b   <= next_pair.b.day;
            req_month_b <= next_pair.b.month;
            req_year_b  <= next_pair.b.year;
            req_valid   <= 1'b1;
            // idle cycles to insert ahead of the transaction after this one
            req_gap = draw_wait(req_calm);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   //---------------------------------------------------------------------------
   // Response stall: draw a fresh wait each time a response moves
   //---------------------------------------------------------------------------
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_taken) rsp_wait = draw_wait(rsp_calm);
         if (rsp_wait > 0) begin
            rsp_stall <= 1'b1;
            rsp_wait--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   //---------------------------------------------------------------------------
   // Monitor: sample both channels at the rising edge
   //---------------------------------------------------------------------------
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, expected_reports.size());
         $display("Regression FAIL");
         $finish;
      end else if (!reset) begin
         req_taken <= req_valid && !req_stall;
         rsp_taken <= rsp_valid && !rsp_stall;

         // Predict the response of each accepted request
         if (req_valid && !req_stall) begin
            next_pair.a = '{req_day_a, req_month_a, req_year_a};
            next_pair.b = '{req_day_b, req_month_b, req_year_b};
            expected_reports.push_back(predict_date_report(next_pair));
         end

         // Compare each accepted response with the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            seen_report = '{rsp_a_valid, rsp_b_valid, rsp_a_day_number, rsp_a_before_b,
                            rsp_dates_equal, rsp_days_between, rsp_next_day_of_month,
                            rsp_next_month, rsp_next_year, rsp_next_overflow};
            if (expected_reports.size() == 0) begin
               failures++;
               if (failures <= MAX_REPORTS)
                  $display("%0t: response with nothing outstanding: %p", $realtime, seen_report);
            end else begin
               want_report = expected_reports.pop_front();
               bad_fields  = "";
               if (seen_report.a_valid !== want_report.a_valid)
                  bad_fields = {bad_fields, " a_valid"};
               if (seen_report.b_valid !== want_report.b_valid)
                  bad_fields = {bad_fields, " b_valid"};
               if (seen_report.a_day_number !== want_report.a_day_number)
                  bad_fields = {bad_fields, " a_day_number"};
               if (seen_report.a_before_b !== want_report.a_before_b)
                  bad_fields = {bad_fields, " a_before_b"};
               if (seen_report.dates_equal !== want_report.dates_equal)
                  bad_fields = {bad_fields, " dates_equal"};
               if (seen_report.days_between !== want_report.days_between)
                  bad_fields = {bad_fields, " days_between"};
               if (seen_report.next_dom !== want_report.next_dom)
                  bad_fields = {bad_fields, " next_day_of_month"};
               if (seen_report.next_month !== want_report.next_month)
                  bad_fields = {bad_fields, " next_month"};
               if (seen_report.next_year !== want_report.next_year)
                  bad_fields = {bad_fields, " next_year"};
               if (seen_report.next_overflow !== want_report.next_overflow)
                  bad_fields = {bad_fields, " next_overflow"};
               if (bad_fields != "") begin
                  failures++;
                  if (failures <= MAX_REPORTS) begin
                     $display("%0t: mismatch on%s", $realtime, bad_fields);
                     $display("   expected %p", want_report);
                     $display("   actual   %p", seen_report);
                  end
               end
            end
         end
      end
   end

   //---------------------------------------------------------------------------
   // Sequence: load stimulus, release reset, drain, report
   //---------------------------------------------------------------------------
   initial begin
      clock       = 1'b0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_day_a   = '0;
      req_month_a = '0;
      req_year_a  = '0;
      req_day_b   = '0;
      req_month_b = '0;
      req_year_b  = '0;
      rsp_stall   = 1'b0;
      req_taken   = 1'b0;
      rsp_taken   = 1'b0;
      req_gap     = 0;
      req_calm    = 0;
      rsp_wait    = 0;
      rsp_calm    = 0;
      cycle_count = 0;
      failures    = 0;

      // Directed: field extremes
      pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 0));
      pending_pairs.push_back(make_pair(31, 15, 16383, 31, 15, 16383));
      // Range ends: first day of the epoch, last representable day, both orders
      pending_pairs.push_back(make_pair(1, 1, 1950, 1, 1, 1950));
      pending_pairs.push_back(make_pair(31, 12, 9999, 1, 1, 1950));
      pending_pairs.push_back(make_pair(1, 1, 1950, 31, 12, 9999));
      pending_pairs.push_back(make_pair(30, 12, 9999, 31, 12, 9999));
      pending_pairs.push_back(make_pair(1, 1, 1949, 1, 1, 1950));
      pending_pairs.push_back(make_pair(1, 1, 10000, 31, 12, 9999));
      // Leap rules: every 400th year leaps, other centuries do not
      pending_pairs.push_back(make_pair(29, 2, 2000, 28, 2, 2000));
      pending_pairs.push_back(make_pair(29, 2, 2100, 1, 1, 2100));
      pending_pairs.push_back(make_pair(28, 2, 2100, 1, 3, 2100));
      pending_pairs.push_back(make_pair(29, 2, 2024, 1, 3, 2024));
      pending_pairs.push_back(make_pair(29, 2, 2023, 1, 1, 2023));
      pending_pairs.push_back(make_pair(31, 1, 2400, 29, 2, 2400));
      pending_pairs.push_back(make_pair(28, 2, 9999, 1, 3, 9999));
      // Month lengths and bad fields
      pending_pairs.push_back(make_pair(31, 4, 2023, 30, 4, 2023));
      pending_pairs.push_back(make_pair(30, 4, 2023, 30, 4, 2023));
      pending_pairs.push_back(make_pair(0, 5, 2023, 1, 5, 2023));
      pending_pairs.push_back(make_pair(15, 0, 2023, 15, 1, 2023));
      pending_pairs.push_back(make_pair(15, 13, 2023, 15, 12, 2023));
      // Year rollover, B invalid with A valid, A later than B
      pending_pairs.push_back(make_pair(31, 12, 2023, 1, 1, 2024));
      pending_pairs.push_back(make_pair(10, 6, 2023, 0, 6, 2023));
      pending_pairs.push_back(make_pair(1, 3, 2024, 28, 2, 2024));

      // Random: mostly valid dates, some equal or nearby, some noise
      for (int unsigned i = 0; i < RANDOM_PAIRS; i++) begin
         case ($urandom_range(0, 9))
            0, 1: begin
               next_pair.a = noise_date();
               next_pair.b = noise_date();
            end
            2: begin
               next_pair.a = random_date();
               next_pair.b = next_pair.a;
            end
            3, 4: begin
               // same month, random day in it
               next_pair.a = random_date();
               next_pair.b = next_pair.a;
               next_pair.b.day = DAY_W'($urandom_range(1,
                  month_length(next_pair.b.month, next_pair.b.year)));
            end
            5: begin
               if ($urandom_range(0, 1)) begin
                  next_pair.a = random_date();
                  next_pair.b = noise_date();
               end else begin
                  next_pair.a = noise_date();
                  next_pair.b = random_date();
               end
            end
            default: begin
               next_pair.a = random_date();
               next_pair.b = random_date();
            end
         endcase
         pending_pairs.push_back(next_pair);
      end

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Drain: all requests sent and every prediction matched
      while (pending_pairs.size() != 0 || req_valid || expected_reports.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (expected_reports.size() != 0) begin
         failures++;
         $display("%0d responses never arrived", expected_reports.size());
      end
      if (failures == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

>>> sim.f
hdl/cdu_pkg.sv
hdl/cdu_date_check.sv
hdl/calendar_date_unit.sv
tb/tb_calendar_date_unit.sv
